FILE: sv/sal_pkg.sv
// Shared types, constants and helpers for the stiffness/admittance axis loop.
// No dependencies; every other file of the block but sal_stream_if imports this package.
package sal_pkg;

  localparam int unsigned NUM_AXES      = 3;   // axes carried by a transaction
  localparam int unsigned AXES_DEFAULT  = 3;
  localparam int unsigned DATA_W        = 32;  // Q16.16
  localparam int unsigned GAIN_W        = 16;  // Q8.8
  localparam int unsigned TIME_W        = 16;  // Q0.16 seconds
  localparam int unsigned CFG_W         = 48;
  localparam int unsigned REG_IDX_W     = 3;
  localparam logic [TIME_W-1:0] MAX_STEP_RESET = 16'd655;

  // Configuration register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_STIFFNESS = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_DESIRED   = 3'd2,
    REG_FGAIN     = 3'd3,
    REG_VLIMIT    = 3'd4,
    REG_NOMINAL   = 3'd5,
    REG_MAX_STEP  = 3'd6
  } sal_reg_e;

  // Request type codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] pos_error_x;
    logic signed [DATA_W-1:0] pos_error_y;
    logic signed [DATA_W-1:0] pos_error_z;
    logic signed [DATA_W-1:0] vel_error_x;
    logic signed [DATA_W-1:0] vel_error_y;
    logic signed [DATA_W-1:0] vel_error_z;
    logic signed [DATA_W-1:0] new_ref_x;
    logic signed [DATA_W-1:0] new_ref_y;
    logic signed [DATA_W-1:0] new_ref_z;
    logic                     update_motion;
    logic [TIME_W-1:0]        elapsed_time;
  } sal_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic signed [DATA_W-1:0] vel_out_x;
    logic signed [DATA_W-1:0] vel_out_y;
    logic signed [DATA_W-1:0] vel_out_z;
    logic signed [DATA_W-1:0] ref_pos_x;
    logic signed [DATA_W-1:0] ref_pos_y;
    logic signed [DATA_W-1:0] ref_pos_z;
    logic                     ref_valid;
  } sal_rsp_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;
  } sal_cfg_t;

  // Step strobes from the sequencer to every lane
  typedef struct packed {
    logic start;    // transaction accepted: latch operands, clear force
    logic load;     // load transaction: take new reference
    logic mul;      // K*pos_err and D*vel_err
    logic frc;      // sum, floor shift, saturate
    logic gmul;     // gain * (desired - force)
    logic vel;      // subtract nominal, clamp to limit
    logic tmul;     // velocity * dt
    logic refu;     // reference advance with saturation
  } sal_lane_ctrl_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [48:0] v);
    logic signed [48:0] max_v;
    logic signed [48:0] min_v;
    max_v = 49'sd2147483647;
    min_v = -49'sd2147483648;
    if (v > max_v) begin
      return 32'sh7fff_ffff;
    end else if (v < min_v) begin
      return 32'sh8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: sv/sal_stream_if.sv
// Valid/ready channel carrying one packed payload per transaction.
// Payload type is given per instance; uses no package.
interface sal_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/sal_lane.sv
// One axis lane: force, velocity and reference arithmetic for a single axis.
// Depends on sal_pkg; stepped by sal_ctrl through sal_lane_ctrl_t.
module sal_lane
  import sal_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sal_lane_ctrl_t           ctrl_i,
  input  logic signed [DATA_W-1:0] pos_err_i,
  input  logic signed [DATA_W-1:0] vel_err_i,
  input  logic signed [DATA_W-1:0] new_ref_i,
  input  logic signed [GAIN_W-1:0] stiff_i,
  input  logic signed [GAIN_W-1:0] damp_i,
  input  logic signed [GAIN_W-1:0] desired_i,
  input  logic signed [GAIN_W-1:0] fgain_i,
  input  logic signed [GAIN_W-1:0] vlimit_i,
  input  logic signed [GAIN_W-1:0] nominal_i,
  input  logic [TIME_W-1:0]        dt_i,
  output logic signed [DATA_W-1:0] force_o,
  output logic signed [DATA_W-1:0] vel_o,
  output logic signed [DATA_W-1:0] ref_o
);

  // operand and product registers
  logic signed [DATA_W-1:0] pe_q, ve_q;
  logic signed [47:0]       kp_q, kp_d, dv_q, dv_d;
  logic signed [48:0]       gp_q, gp_d;
  logic signed [48:0]       tp_q, tp_d;

  // state
  logic signed [DATA_W-1:0] force_q, force_d;
  logic signed [DATA_W-1:0] vel_q, vel_d;
  logic signed [DATA_W-1:0] ref_q, ref_d;

  // widened Q8.8 -> Q16.16 constants
  logic signed [23:0] des_w, nom_w, lim_w;
  logic signed [48:0] frc_sum;
  logic signed [32:0] diff;
  logic signed [41:0] v_raw, v_hi, v_lo;
  logic signed [48:0] ref_sum;

  assign des_w = {desired_i, 8'h00};
  assign nom_w = {nominal_i, 8'h00};
  assign lim_w = {vlimit_i, 8'h00};

  // exact products, K*pe and D*ve both taken in the mul step
  assign kp_d = stiff_i * pe_q;
  assign dv_d = damp_i * ve_q;

  // force = floor((K*pe + D*ve) / 256), saturated
  assign frc_sum = 49'(kp_q) + 49'(dv_q);
  assign force_d = sat32(frc_sum >>> 8);

  // gain * (desired - force)
  assign diff = 33'(des_w) - 33'(force_q);
  assign gp_d = fgain_i * diff;

  // velocity with limit clamp; upper bound checked first
  assign v_raw = 42'(gp_q >>> 8) - 42'(nom_w);
  assign v_hi  = 42'(lim_w);
  assign v_lo  = -v_hi;
  always_comb begin
    priority if (v_raw > v_hi) begin
      vel_d = v_hi[DATA_W-1:0];
    end else if (v_raw < v_lo) begin
      vel_d = v_lo[DATA_W-1:0];
    end else begin
      vel_d = v_raw[DATA_W-1:0];
    end
  end

  // reference step: floor(vel*dt / 2^16), saturated
  assign tp_d    = vel_q * $signed({1'b0, dt_i});
  assign ref_sum = 49'(ref_q) + (tp_q >>> 16);
  assign ref_d   = sat32(ref_sum);

  // operand and product registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      pe_q <= pos_err_i;
      ve_q <= vel_err_i;
    end
    if (ctrl_i.mul) begin
      kp_q <= kp_d;
      dv_q <= dv_d;
    end
    if (ctrl_i.gmul) begin
      gp_q <= gp_d;
    end
    if (ctrl_i.tmul) begin
      tp_q <= tp_d;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q <= '0;
      vel_q   <= '0;
      ref_q   <= '0;
    end else begin
      if (ctrl_i.start) begin
        force_q <= '0;
      end else if (ctrl_i.frc) begin
        force_q <= force_d;
      end
      if (ctrl_i.vel) begin
        vel_q <= vel_d;
      end
      if (ctrl_i.load) begin
        ref_q <= new_ref_i;
      end else if (ctrl_i.refu) begin
        ref_q <= ref_d;
      end
    end
  end

  assign force_o = force_q;
  assign vel_o   = vel_q;
  assign ref_o   = ref_q;

endmodule

FILE: sv/sal_ctrl.sv
// Sequencer: accepts one transaction at a time and steps all lanes together.
// Depends on sal_pkg; drives sal_lane_ctrl_t and the capture strobe of sal_merge.
module sal_ctrl
  import sal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic              motion_i,
  input  logic [TIME_W-1:0] elapsed_i,
  input  logic [TIME_W-1:0] max_step_i,
  input  logic              out_busy_i,
  output sal_lane_ctrl_t    lane_ctrl_o,
  output logic [TIME_W-1:0] dt_o,
  output logic              ref_valid_o,
  output logic              capture_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FRC,
    ST_GMUL,
    ST_VEL,
    ST_TMUL,
    ST_REF,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic              motion_q;
  logic              ref_valid_q;
  logic [TIME_W-1:0] dt_q;
  logic              accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign capture_o  = (state_q == ST_EMIT) && !out_busy_i;

  // per-step strobes to the lanes
  always_comb begin
    lane_ctrl_o       = '0;
    lane_ctrl_o.start = accept;
    lane_ctrl_o.load  = accept && (req_type_i == REQ_LOAD);
    lane_ctrl_o.mul   = (state_q == ST_MUL);
    lane_ctrl_o.frc   = (state_q == ST_FRC);
    lane_ctrl_o.gmul  = (state_q == ST_GMUL);
    lane_ctrl_o.vel   = (state_q == ST_VEL);
    lane_ctrl_o.tmul  = (state_q == ST_TMUL);
    lane_ctrl_o.refu  = (state_q == ST_REF);
  end

  // state and registered controls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      motion_q    <= 1'b0;
      ref_valid_q <= 1'b0;
      dt_q        <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            motion_q <= motion_i;
            dt_q     <= (elapsed_i < max_step_i) ? elapsed_i : max_step_i;
            if (req_type_i == REQ_LOAD) begin
              ref_valid_q <= 1'b1;
              state_q     <= ST_EMIT;
            end else if (ref_valid_q) begin
              state_q <= ST_MUL;
            end else begin
              // compute before any load: force stays zero
              state_q <= ST_EMIT;
            end
          end
        end
        ST_MUL:  state_q <= ST_FRC;
        ST_FRC:  state_q <= motion_q ? ST_GMUL : ST_EMIT;
        ST_GMUL: state_q <= ST_VEL;
        ST_VEL:  state_q <= ST_TMUL;
        ST_TMUL: state_q <= ST_REF;
        ST_REF:  state_q <= ST_EMIT;
        ST_EMIT: begin
          if (!out_busy_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign dt_o        = dt_q;
  assign ref_valid_o = ref_valid_q;

endmodule

FILE: sv/sal_merge.sv
// Result stage: gathers the lane outputs into one result and holds it
// until the receiver takes it. Depends on sal_pkg and sal_stream_if.
module sal_merge
  import sal_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     capture_i,
  input  logic signed [DATA_W-1:0] force_i [NUM_AXES],
  input  logic signed [DATA_W-1:0] vel_i   [NUM_AXES],
  input  logic signed [DATA_W-1:0] ref_i   [NUM_AXES],
  input  logic                     ref_valid_i,
  output logic                     busy_o,
  sal_stream_if.source             out_o
);

  logic     valid_q;
  sal_rsp_t data_q;
  sal_rsp_t data_d;

  // pack the lanes into the result layout
  always_comb begin
    data_d.force_x   = force_i[0];
    data_d.force_y   = force_i[1];
    data_d.force_z   = force_i[2];
    data_d.vel_out_x = vel_i[0];
    data_d.vel_out_y = vel_i[1];
    data_d.vel_out_z = vel_i[2];
    data_d.ref_pos_x = ref_i[0];
    data_d.ref_pos_y = ref_i[1];
    data_d.ref_pos_z = ref_i[2];
    data_d.ref_valid = ref_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (capture_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      data_q <= data_d;
    end
  end

  assign busy_o      = valid_q && !out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

FILE: sv/stiffness_admittance_axis_loop_core.sv
// Three-axis stiffness/damping controller with force-tracking admittance.
//
// Channels: in_i (sal_req_t) takes load and compute transactions, out_o
// (sal_rsp_t) returns exactly one result per transaction, cfg_i (sal_cfg_t)
// writes the seven configuration registers and is always ready.
// From the accepting input edge the sequencer steps through these states
// before out_o can hand the result over:
//   load, or compute before any reference is loaded:  EMIT
//   compute without motion update:                     MUL, FRC, EMIT
//   compute with motion update:   MUL, FRC, GMUL, VEL, TMUL, REF, EMIT
// One transaction is in flight at a time; in_ready returns with the edge
// that places the result in the output register, so no new transaction is
// taken before the last one's result is registered. The per-axis chain of
// dependent multiplies (K/D, force gain, velocity*dt), each with its own
// register, makes up the compute steps; all axes run in parallel lanes.
// Reset clears reference, velocity, force and the loaded flag, zeroes the
// gain registers and sets the step-time clamp to 655. If the receiver
// stalls, the result is held in the output register, the sequencer waits
// with the next result and no new transaction is taken until it drains.
// Depends on sal_pkg, sal_stream_if, sal_lane, sal_ctrl and sal_merge.
module stiffness_admittance_axis_loop_core
  import sal_pkg::*;
#(
  parameter int unsigned AXES = AXES_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sal_stream_if.sink   in_i,
  sal_stream_if.source out_o,
  sal_stream_if.sink   cfg_i
);

  localparam int unsigned LANES = (AXES < NUM_AXES) ? AXES : NUM_AXES;

  // configuration registers
  logic [CFG_W-1:0]  stiff_q, damp_q, desired_q, fgain_q, vlimit_q, nominal_q;
  logic [TIME_W-1:0] max_step_q;
  sal_reg_e          cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = sal_reg_e'(cfg_i.data.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q    <= '0;
      damp_q     <= '0;
      desired_q  <= '0;
      fgain_q    <= '0;
      vlimit_q   <= '0;
      nominal_q  <= '0;
      max_step_q <= MAX_STEP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx)
        REG_STIFFNESS: stiff_q    <= cfg_i.data.wdata;
        REG_DAMPING:   damp_q     <= cfg_i.data.wdata;
        REG_DESIRED:   desired_q  <= cfg_i.data.wdata;
        REG_FGAIN:     fgain_q    <= cfg_i.data.wdata;
        REG_VLIMIT:    vlimit_q   <= cfg_i.data.wdata;
        REG_NOMINAL:   nominal_q  <= cfg_i.data.wdata;
        REG_MAX_STEP:  max_step_q <= cfg_i.data.wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  sal_lane_ctrl_t    lane_ctrl;
  logic [TIME_W-1:0] dt;
  logic              ref_valid;
  logic              capture;
  logic              out_busy;

  sal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .req_type_i  (in_i.data.req_type),
    .motion_i    (in_i.data.update_motion),
    .elapsed_i   (in_i.data.elapsed_time),
    .max_step_i  (max_step_q),
    .out_busy_i  (out_busy),
    .lane_ctrl_o (lane_ctrl),
    .dt_o        (dt),
    .ref_valid_o (ref_valid),
    .capture_o   (capture)
  );

  // per-axis operands
  logic signed [DATA_W-1:0] pe_w    [NUM_AXES];
  logic signed [DATA_W-1:0] ve_w    [NUM_AXES];
  logic signed [DATA_W-1:0] nref_w  [NUM_AXES];
  logic signed [DATA_W-1:0] force_w [NUM_AXES];
  logic signed [DATA_W-1:0] vel_w   [NUM_AXES];
  logic signed [DATA_W-1:0] ref_w   [NUM_AXES];

  assign pe_w[0]   = in_i.data.pos_error_x;
  assign pe_w[1]   = in_i.data.pos_error_y;
  assign pe_w[2]   = in_i.data.pos_error_z;
  assign ve_w[0]   = in_i.data.vel_error_x;
  assign ve_w[1]   = in_i.data.vel_error_y;
  assign ve_w[2]   = in_i.data.vel_error_z;
  assign nref_w[0] = in_i.data.new_ref_x;
  assign nref_w[1] = in_i.data.new_ref_y;
  assign nref_w[2] = in_i.data.new_ref_z;

  // lanes; axes past the configured count stay at zero
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    if (a < LANES) begin : g_lane
      sal_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (lane_ctrl),
        .pos_err_i (pe_w[a]),
        .vel_err_i (ve_w[a]),
        .new_ref_i (nref_w[a]),
        .stiff_i   (stiff_q[GAIN_W*a +: GAIN_W]),
        .damp_i    (damp_q[GAIN_W*a +: GAIN_W]),
        .desired_i (desired_q[GAIN_W*a +: GAIN_W]),
        .fgain_i   (fgain_q[GAIN_W*a +: GAIN_W]),
        .vlimit_i  (vlimit_q[GAIN_W*a +: GAIN_W]),
        .nominal_i (nominal_q[GAIN_W*a +: GAIN_W]),
        .dt_i      (dt),
        .force_o   (force_w[a]),
        .vel_o     (vel_w[a]),
        .ref_o     (ref_w[a])
      );
    end else begin : g_idle
      assign force_w[a] = '0;
      assign vel_w[a]   = '0;
      assign ref_w[a]   = '0;
    end
  end

  // result register
  sal_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capture_i   (capture),
    .force_i     (force_w),
    .vel_i       (vel_w),
    .ref_i       (ref_w),
    .ref_valid_i (ref_valid),
    .busy_o      (out_busy),
    .out_o       (out_o)
  );

endmodule

FILE: sv/sal_checker.sv
// Port-level checks for stiffness_admittance_axis_loop_core, bound to it.
// Depends on sal_pkg for the request codes.
module sal_checker
  import sal_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_req_type_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     out_ref_valid_i,
  input logic signed [DATA_W-1:0] out_force_x_i,
  input logic signed [DATA_W-1:0] out_force_y_i,
  input logic signed [DATA_W-1:0] out_force_z_i
);

  // one transaction in flight: input closes right after an acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a transaction is in flight");

  // before any reference is loaded the force is zero
  a_force_zero_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ref_valid_i |->
      out_force_x_i == '0 && out_force_y_i == '0 && out_force_z_i == '0)
    else $error("nonzero force without a loaded reference");

  // a load into an empty output stage passes the state register and the result register and shows up flagged valid
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_req_type_i == REQ_LOAD && !out_valid_i |->
      ##2 (out_valid_i && out_ref_valid_i))
    else $error("load result missing or reference not flagged");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_force_x_i) &&
      $stable(out_ref_valid_i))
    else $error("result dropped or changed while stalled");

endmodule

bind stiffness_admittance_axis_loop_core sal_checker u_sal_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_req_type_i   (in_i.data.req_type),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_ref_valid_i (out_o.data.ref_valid),
  .out_force_x_i   (out_o.data.force_x),
  .out_force_y_i   (out_o.data.force_y),
  .out_force_z_i   (out_o.data.force_z)
);

FILE: bench/stiffness_admittance_axis_loop_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the three-axis stiffness/admittance control loop.
// Mirrors force, velocity and reference updates in its own model and checks
// every result. Depends on sal_pkg, sal_stream_if and the core.
module stiffness_admittance_axis_loop_core_tb;
  import sal_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;  // not mapped, writes ignored
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [GAIN_W-1:0] G_MAX = 16'h7fff;
  localparam logic [GAIN_W-1:0] G_MIN = 16'h8000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sal_stream_if #(.payload_t(sal_req_t)) in_if ();
  sal_stream_if #(.payload_t(sal_rsp_t)) out_if ();
  sal_stream_if #(.payload_t(sal_cfg_t)) cfg_if ();

  stiffness_admittance_axis_loop_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Control loop mirror: configuration and state
  logic [CFG_W-1:0]         k_gains, d_gains, force_targets, force_gains;
  logic [CFG_W-1:0]         vel_limits, nominal_vels;
  logic [TIME_W-1:0]        step_clamp;
  logic signed [DATA_W-1:0] ref_pos [NUM_AXES];
  logic signed [DATA_W-1:0] vel_state [NUM_AXES];
  logic                     ref_loaded;

  sal_rsp_t pending_results [$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  // Signed Q8.8 gain of one axis, x in the low lane
  function automatic longint axis_gain(input logic [CFG_W-1:0] r, input int ax);
    return longint'($signed(r[GAIN_W*ax +: GAIN_W]));
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Advance the mirror by one transaction and return the result it yields
  function automatic sal_rsp_t predict_control_step(input sal_req_t req);
    logic signed [DATA_W-1:0] pos_err [NUM_AXES];
    logic signed [DATA_W-1:0] vel_err [NUM_AXES];
    logic signed [DATA_W-1:0] new_ref [NUM_AXES];
    logic signed [DATA_W-1:0] frc [NUM_AXES];
    longint acc, diff, v, lim, dt;
    sal_rsp_t rsp;
    pos_err = '{req.pos_error_x, req.pos_error_y, req.pos_error_z};
    vel_err = '{req.vel_error_x, req.vel_error_y, req.vel_error_z};
    new_ref = '{req.new_ref_x, req.new_ref_y, req.new_ref_z};
    dt = (req.elapsed_time < step_clamp) ? req.elapsed_time : step_clamp;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      frc[ax] = '0;
      if (req.req_type == REQ_LOAD) begin
        ref_pos[ax] = new_ref[ax];
      end else if (ref_loaded) begin
        acc = axis_gain(k_gains, ax) * pos_err[ax] + axis_gain(d_gains, ax) * vel_err[ax];
        frc[ax] = clamp_q16(acc >>> 8);
        if (req.update_motion) begin
          diff = axis_gain(force_targets, ax) * 256 - frc[ax];
          v = ((axis_gain(force_gains, ax) * diff) >>> 8) - axis_gain(nominal_vels, ax) * 256;
          lim = axis_gain(vel_limits, ax) * 256;
          // upper bound wins, so with a negative limit v ends on the limit or its negation
          if (v > lim) begin
            v = lim;
          end else if (v < -lim) begin
            v = -lim;
          end
          vel_state[ax] = v[DATA_W-1:0];
          ref_pos[ax] = clamp_q16(ref_pos[ax] + ((v * dt) >>> 16));
        end
      end
    end
    if (req.req_type == REQ_LOAD) ref_loaded = 1'b1;
    rsp.force_x   = frc[0];
    rsp.force_y   = frc[1];
    rsp.force_z   = frc[2];
    rsp.vel_out_x = vel_state[0];
    rsp.vel_out_y = vel_state[1];
    rsp.vel_out_z = vel_state[2];
    rsp.ref_pos_x = ref_pos[0];
    rsp.ref_pos_y = ref_pos[1];
    rsp.ref_pos_z = ref_pos[2];
    rsp.ref_valid = ref_loaded;
    return rsp;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endfunction

  // Result checker: each accepted result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    sal_rsp_t got;
    sal_rsp_t want;
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("force_x",   want.force_x,   got.force_x);
        check_field("force_y",   want.force_y,   got.force_y);
        check_field("force_z",   want.force_z,   got.force_z);
        check_field("vel_out_x", want.vel_out_x, got.vel_out_x);
        check_field("vel_out_y", want.vel_out_y, got.vel_out_y);
        check_field("vel_out_z", want.vel_out_z, got.vel_out_z);
        check_field("ref_pos_x", want.ref_pos_x, got.ref_pos_x);
        check_field("ref_pos_y", want.ref_pos_y, got.ref_pos_y);
        check_field("ref_pos_z", want.ref_pos_z, got.ref_pos_z);
        check_field("ref_valid", 32'(want.ref_valid), 32'(got.ref_valid));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [CFG_W-1:0] pack_axes(input logic [GAIN_W-1:0] x, y, z);
    return {z, y, x};
  endfunction

  function automatic logic signed [DATA_W-1:0] random_q16();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       return ($urandom_range(0, 1) == 0) ? Q_MAX : Q_MIN;
      default: return 32'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_gain_set(input bit wide);
    logic [CFG_W-1:0] r;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      r[GAIN_W*ax +: GAIN_W] = wide ? 16'($urandom()) : 16'($urandom_range(0, 2048) - 1024);
    end
    return r;
  endfunction

  function automatic sal_req_t random_request();
    sal_req_t req;
    req.req_type      = ($urandom_range(0, 99) < 8) ? REQ_LOAD : REQ_COMPUTE;
    req.pos_error_x   = random_q16();
    req.pos_error_y   = random_q16();
    req.pos_error_z   = random_q16();
    req.vel_error_x   = random_q16();
    req.vel_error_y   = random_q16();
    req.vel_error_z   = random_q16();
    req.new_ref_x     = random_q16();
    req.new_ref_y     = random_q16();
    req.new_ref_z     = random_q16();
    req.update_motion = ($urandom_range(0, 3) != 0);
    req.elapsed_time  = ($urandom_range(0, 1) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 1500));
    return req;
  endfunction

  // Load with random content in the fields a load ignores
  function automatic sal_req_t load_request(input logic signed [DATA_W-1:0] x, y, z);
    sal_req_t req;
    req = random_request();
    req.req_type  = REQ_LOAD;
    req.new_ref_x = x;
    req.new_ref_y = y;
    req.new_ref_z = z;
    return req;
  endfunction

  function automatic sal_req_t compute_request(
    input logic signed [DATA_W-1:0] pex, pey, pez, vex, vey, vez,
    input logic motion, input logic [TIME_W-1:0] elapsed);
    sal_req_t req;
    req = random_request();
    req.req_type      = REQ_COMPUTE;
    req.pos_error_x   = pex;
    req.pos_error_y   = pey;
    req.pos_error_z   = pez;
    req.vel_error_x   = vex;
    req.vel_error_y   = vey;
    req.vel_error_z   = vez;
    req.update_motion = motion;
    req.elapsed_time  = elapsed;
    return req;
  endfunction

  // One input transaction; valid stays up when the next one follows at once
  task automatic send_request(input sal_req_t req);
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_control_step(req));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic write_setting(input logic [REG_IDX_W-1:0] index,
                               input logic [CFG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {index, value};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    unique case (index)
      REG_STIFFNESS: k_gains       = value;
      REG_DAMPING:   d_gains       = value;
      REG_DESIRED:   force_targets = value;
      REG_FGAIN:     force_gains   = value;
      REG_VLIMIT:    vel_limits    = value;
      REG_NOMINAL:   nominal_vels  = value;
      REG_MAX_STEP:  step_clamp    = value[TIME_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Gains set, step clamp left at reset; compute before any load must do nothing, then a load and a motion compute run
  task automatic test_reset_defaults();
    sal_req_t req;
    write_setting(REG_STIFFNESS, pack_axes(16'h0100, 16'hff00, 16'h0080));
    write_setting(REG_DAMPING,   pack_axes(16'h0040, 16'h0020, 16'hffc0));
    write_setting(REG_DESIRED,   pack_axes(16'h0200, 16'hfe00, 16'h0000));
    write_setting(REG_FGAIN,     pack_axes(16'h0080, 16'h0100, 16'h0040));
    write_setting(REG_VLIMIT,    pack_axes(16'h0400, 16'h0400, 16'h0400));
    write_setting(REG_NOMINAL,   pack_axes(16'h0010, 16'hfff0, 16'h0008));
    req = random_request();
    req.req_type      = REQ_COMPUTE;
    req.update_motion = 1'b1;
    send_request(req);
    send_request(load_request(32'sh0001_0000, -32'sh0002_0000, 32'sh0));
    send_request(compute_request(32'sh0000_8000, 32'sh0001_0000, -32'sh0000_4000,
                                 32'sh0000_2000, -32'sh0000_1000, 32'sh0, 1'b1, 16'hffff));
  endtask

  // Gain and error extremes drive the force into saturation both ways
  task automatic test_force_saturation();
    wait_drained();
    write_setting(REG_STIFFNESS, pack_axes(G_MAX, G_MAX, G_MAX));
    write_setting(REG_DAMPING,   pack_axes(G_MAX, G_MIN, 16'h0000));
    write_setting(REG_UNUSED,    '1);
    send_request(compute_request(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 16'h0));
    send_request(compute_request(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 32'sh0, 1'b0, 16'h0));
    send_request(compute_request(Q_MAX, Q_MIN, 32'sh0, Q_MIN, Q_MIN, -32'sh1, 1'b0, 16'hffff));
    wait_drained();
    write_setting(REG_STIFFNESS, pack_axes(G_MIN, G_MIN, 16'h0001));
    write_setting(REG_DAMPING,   pack_axes(G_MIN, 16'h0001, 16'hffff));
    send_request(compute_request(Q_MIN, Q_MAX, -32'sh1, Q_MIN, 32'sh1, Q_MIN, 1'b0, 16'h0));
  endtask

  // Velocity clamp at both bounds, reference saturation, negative and zero limits
  task automatic test_velocity_clamp();
    wait_drained();
    write_setting(REG_STIFFNESS, '0);
    write_setting(REG_DAMPING,   '0);
    write_setting(REG_DESIRED,   pack_axes(G_MAX, G_MIN, G_MAX));
    write_setting(REG_FGAIN,     pack_axes(G_MAX, G_MAX, G_MIN));
    write_setting(REG_VLIMIT,    pack_axes(G_MAX, G_MAX, G_MAX));
    write_setting(REG_NOMINAL,   pack_axes(G_MIN, G_MAX, 16'h0000));
    write_setting(REG_MAX_STEP,  48'h0000_0000_ffff);
    send_request(load_request(32'sh7fff_0000, 32'sh8001_0000, 32'sh0));
    send_request(compute_request('0, '0, '0, '0, '0, '0, 1'b1, 16'hffff));
    wait_drained();
    write_setting(REG_VLIMIT, pack_axes(G_MIN, 16'h0000, 16'hfff0));
    send_request(compute_request('0, '0, '0, '0, '0, '0, 1'b1, 16'hffff));
    send_request(compute_request(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1, 16'h8000));
  endtask

  // Elapsed time clamped by the step limit, including a zero limit
  task automatic test_step_clamp();
    wait_drained();
    write_setting(REG_STIFFNESS, pack_axes(16'h0100, 16'h0080, 16'hff80));
    write_setting(REG_VLIMIT,    pack_axes(16'h0100, 16'h0100, 16'h0100));
    write_setting(REG_MAX_STEP,  48'hffff_ffff_0000);  // upper bits dropped: clamp of zero
    send_request(compute_request(32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000,
                                 '0, '0, '0, 1'b1, 16'hffff));
    wait_drained();
    write_setting(REG_MAX_STEP, 48'h0000_0000_0100);
    send_request(compute_request(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                                 '0, '0, '0, 1'b1, 16'h00ff));
    send_request(compute_request(-32'sh0001_0000, 32'sh0003_0000, 32'sh0,
                                 '0, '0, '0, 1'b1, 16'h0101));
    send_request(compute_request(32'sh0001_0000, '0, '0, '0, '0, '0, 1'b1, 16'h0000));
  endtask

  // Without motion, and across a load, the velocity holds
  task automatic test_hold_without_motion();
    send_request(compute_request(random_q16(), random_q16(), random_q16(),
                                 random_q16(), random_q16(), random_q16(), 1'b0, 16'hffff));
    send_request(load_request(Q_MIN, Q_MAX, -32'sh1));
    send_request(compute_request(32'sh0000_0001, -32'sh0000_0001, Q_MAX,
                                 Q_MIN, '0, 32'sh1, 1'b0, 16'h0100));
  endtask

  // Random traffic under one setting and one idling profile
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input bit wide, input int count);
    wait_drained();
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    for (int r = REG_STIFFNESS; r <= REG_NOMINAL; r++) begin
      write_setting(r[REG_IDX_W-1:0], random_gain_set(wide));
    end
    write_setting(REG_MAX_STEP, wide ? 48'($urandom()) : 48'($urandom_range(0, 2000)));
    if ($urandom_range(0, 3) == 0) write_setting(REG_UNUSED, 48'({$urandom(), $urandom()}));
    for (int n = 0; n < count; n++) begin
      send_request(random_request());
    end
  endtask

  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    k_gains       = '0;
    d_gains       = '0;
    force_targets = '0;
    force_gains   = '0;
    vel_limits    = '0;
    nominal_vels  = '0;
    step_clamp    = MAX_STEP_RESET;
    ref_loaded    = 1'b0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      ref_pos[ax]   = '0;
      vel_state[ax] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_idle_pct  = 7;
    recv_stall_pct = 85;
    test_reset_defaults();
    test_force_saturation();
    test_velocity_clamp();
    test_step_clamp();
    test_hold_without_motion();

    test_random_traffic(7, 85, 1'b0, 320);
    test_random_traffic(7, 85, 1'b1, 310);
    test_random_traffic(85, 7, 1'b0, 320);
    test_random_traffic(85, 7, 1'b1, 310);
    test_random_traffic(0, 0, 1'b0, 320);
    test_random_traffic(0, 0, 1'b1, 320);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/sal_pkg.sv
sv/sal_stream_if.sv
sv/sal_lane.sv
sv/sal_ctrl.sv
sv/sal_merge.sv
sv/stiffness_admittance_axis_loop_core.sv
sv/sal_checker.sv
bench/stiffness_admittance_axis_loop_core_tb.sv
